// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// shared types, constants and codes of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int CAPACITY = 64;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int VALUE_W = 32;
   localparam int OUT_CNT_W = 7;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0] count_type;
   typedef logic [OUT_CNT_W-1:0] out_count_type;
   typedef logic [1:0] cmd_type;
   typedef logic [1:0] status_type;

   localparam cmd_type CMD_ENQUEUE = 2'd0;
   localparam cmd_type CMD_DEQUEUE = 2'd1;
   localparam cmd_type CMD_PEEK = 2'd2;

   localparam status_type ST_OK = 2'd0;
   localparam status_type ST_OVERFLOW = 2'd1;
   localparam status_type ST_UNDERFLOW = 2'd2;

   // broadcast to every cell of the row
   typedef struct packed {
      logic enq;
      logic deq;
      value_type value;
   } cell_ctl_type;

endpackage

// ===== sv/spq_req_if.sv =====
// ----------------------------------------------------------------------------
// spq_req_if
// command channel: valid, ready and one command word
// ----------------------------------------------------------------------------
interface spq_req_if;
   logic valid;
   logic ready;
   spq_pkg::cmd_type cmd;
   spq_pkg::value_type item_value;

   modport source (output valid, output cmd, output item_value, input ready);
   modport sink (input valid, input cmd, input item_value, output ready);
endinterface

// ===== sv/spq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// spq_rsp_if
// result channel: valid, ready and one result word
// ----------------------------------------------------------------------------
interface spq_rsp_if;
   logic valid;
   logic ready;
   spq_pkg::value_type head_value;
   spq_pkg::status_type status;
   spq_pkg::out_count_type entry_count;

   modport source (output valid, output head_value, output status,
                   output entry_count, input ready);
   modport sink (input valid, input head_value, input status,
                 input entry_count, output ready);
endinterface

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted row: holds an entry, compares it with the new
// value and takes its own, the new or a neighbor's entry
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                   clock,
   input  spq_pkg::cell_ctl_type  ctl,
   input  logic                   occupied,
   input  spq_pkg::value_type     left_entry,
   input  logic                   left_ge,
   input  spq_pkg::value_type     right_entry,
   output spq_pkg::value_type     entry,
   output logic                   ge
);

   spq_pkg::value_type entry_ff;
   spq_pkg::value_type entry_in;

   // stored entry is not smaller than the new value
   assign ge = occupied && (entry_ff >= ctl.value);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.enq) begin
         if (ge) begin
            entry_in = entry_ff;
         end else if (left_ge) begin
            entry_in = ctl.value;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctl.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== sv/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// max-priority queue kept as a sorted row of cells, largest value at the head
// ----------------------------------------------------------------------------
// req carries one command word: enqueue, dequeue or peek, plus a signed
// value used by enqueue. rsp returns one word per command: the head value
// (removed value on dequeue), a status and the entry count afterwards.
// Every cell compares its entry with the broadcast value in parallel, so
// an insert, a removal or a peek completes in the cycle it is accepted:
// one command per cycle while the receiver takes results, and the result
// is valid in the cycle after acceptance. The result register decouples
// the two sides: a new command is taken while no result is pending or the
// pending one is taken in the same cycle. When the receiver stalls the
// result holds and req.ready drops. An enqueue on a full queue is
// rejected with overflow; dequeue or peek on an empty queue reports
// underflow with value 0. Reset empties the queue (count to zero) and
// clears the result valid; the entries themselves are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
   input  logic         clock,
   input  logic         reset,
   spq_req_if.sink      req_ch,
   spq_rsp_if.source    rsp_ch
);

   localparam int CAP = spq_pkg::CAPACITY;

   spq_pkg::count_type      count_ff, count_in;
   logic                    rsp_valid_ff;
   spq_pkg::value_type      rsp_head_ff, rsp_head_in;
   spq_pkg::status_type     rsp_status_ff, rsp_status_in;
   spq_pkg::out_count_type  rsp_count_ff;

   spq_pkg::cell_ctl_type   ctl;
   spq_pkg::value_type      entry_w [CAP];
   logic                    ge_w [CAP];

   logic accept;
   logic full;
   logic empty;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;
   assign full = (count_ff == spq_pkg::count_type'(CAP));
   assign empty = (count_ff == '0);

   always_comb begin
      ctl.enq = 1'b0;
      ctl.deq = 1'b0;
      ctl.value = req_ch.item_value;
      count_in = count_ff;
      rsp_status_in = spq_pkg::ST_OK;
      rsp_head_in = entry_w[0];
      case (req_ch.cmd)
         spq_pkg::CMD_ENQUEUE: begin
            if (full) begin
               rsp_status_in = spq_pkg::ST_OVERFLOW;
            end else begin
               ctl.enq = accept;
               count_in = count_ff + 1'b1;
               rsp_head_in = ge_w[0] ? entry_w[0] : req_ch.item_value;
            end
         end
         spq_pkg::CMD_DEQUEUE: begin
            if (empty) begin
               rsp_status_in = spq_pkg::ST_UNDERFLOW;
               rsp_head_in = '0;
            end else begin
               ctl.deq = accept;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            if (empty) begin
               rsp_status_in = spq_pkg::ST_UNDERFLOW;
               rsp_head_in = '0;
            end
         end
      endcase
   end

   genvar i;
   generate
      for (i = 0; i < CAP; i++) begin : g_cell
         spq_pkg::value_type left_entry;
         logic               left_ge;
         spq_pkg::value_type right_entry;
         if (i == 0) begin : g_first
            assign left_entry = req_ch.item_value;
            assign left_ge = 1'b1;
         end else begin : g_inner
            assign left_entry = entry_w[i-1];
            assign left_ge = ge_w[i-1];
         end
         if (i == CAP - 1) begin : g_last
            assign right_entry = entry_w[i];
         end else begin : g_mid
            assign right_entry = entry_w[i+1];
         end
         spq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occupied    (count_ff > spq_pkg::count_type'(i)),
            .left_entry  (left_entry),
            .left_ge     (left_ge),
            .right_entry (right_entry),
            .entry       (entry_w[i]),
            .ge          (ge_w[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_head_ff <= rsp_head_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff <= spq_pkg::out_count_type'(count_in);
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.head_value = rsp_head_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spq_pkg::count_type'(CAP))
      else $error("entry count above capacity");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      count_ff >= spq_pkg::count_type'(2) |-> entry_w[0] >= entry_w[1])
      else $error("head smaller than second entry");

   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.cmd == spq_pkg::CMD_DEQUEUE && !empty
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("dequeue did not decrement count");

   a_overflow: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.cmd == spq_pkg::CMD_ENQUEUE && full
      |=> rsp_status_ff == spq_pkg::ST_OVERFLOW && count_ff == $past(count_ff))
      else $error("enqueue on full queue not rejected");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted command gave no result");

endmodule
